// ===== hw/rtl/two_key_ternary_tree_engine_defines.svh =====
// Assertion macros for the two-key ternary tree engine.
// Holds no logic; included by the RTL files that carry assertions.
`ifndef TWO_KEY_TERNARY_TREE_ENGINE_DEFINES_SVH
`define TWO_KEY_TERNARY_TREE_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define TTE_ASSERT_HOLDS(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("tree engine check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define TTE_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("tree engine check failed");
`else
`define TTE_ASSERT_HOLDS(label, clk_sig, rst_sig, ante, cons)
`define TTE_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons)
`endif
`endif

// ===== hw/rtl/tkte_pkg.sv =====
// Package for the two-key ternary tree engine: default sizes, request and
// status codes, branch codes and the sequencer state type. No dependencies.
`default_nettype none

package tkte_pkg;

  localparam int NODE_COUNT_DEF = 64;
  localparam int KEY_WIDTH_DEF  = 32;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  localparam logic STAT_DONE = 1'b0;
  localparam logic STAT_FULL = 1'b1;

  typedef enum logic [1:0] {
    BR_LEFT  = 2'd0,
    BR_MID   = 2'd1,
    BR_RIGHT = 2'd2
  } branch_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_CMP_LO,
    S_CMP_HI,
    S_ALLOC,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/two_key_ternary_tree_engine.sv =====
// Top level of the two-key ternary tree engine: node pool memory, shared key
// comparator and the walk sequencer. Depends on tkte_pkg and the defines header.
`include "two_key_ternary_tree_engine_defines.svh"
`default_nettype none

// Search-tree engine over a pool of NODE_COUNT nodes. Each node holds a low
// and a high key (kept in order) plus left, middle and right child links.
// A request transfer carries req_type (insert or search) and a signed key;
// every request produces exactly one result transfer with found and status.
// An insert walks from the root: a key at or below the low key goes left, a
// key above the high key goes right, anything else goes middle, and the key
// lands in the first node with a free slot. When the walk leaves the tree a
// new node is taken from the pool; if the pool is exhausted the insert is
// dropped and status reports full. Nodes are handed out in order and never
// freed, so every allocated node is written whole on its first use and the
// pool needs no clearing pass after reset: the engine is ready at once.
// The block takes one request at a time. Each tree level is a node memory
// read (S_FETCH), then two passes through the single shared key comparator,
// low key then high key (S_CMP_LO, S_CMP_HI); allocating a node adds the
// S_ALLOC state, and every request ends in the result state S_DONE. The walk
// grows with the number of nodes visited, up to every node for a search
// through a fully degenerate tree, as the node memory has one read port and
// there is one comparator. A finished result waits in an output register,
// and the next request transfer is taken while it waits.
module two_key_ternary_tree_engine #(
  parameter int NODE_COUNT = tkte_pkg::NODE_COUNT_DEF,
  parameter int KEY_WIDTH  = tkte_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        req_type,
  input  wire logic signed [KEY_WIDTH-1:0] key,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             found,
  output logic                             status
);

  // Node index width and the width of the allocation count, which must be
  // able to hold NODE_COUNT itself.
  localparam int AW = $clog2(NODE_COUNT);
  localparam int CW = $clog2(NODE_COUNT + 1);

  // One pool entry. The low key of a node reached through a link is always
  // valid, so only the high slot carries a valid flag; the root's low slot
  // is tracked by root_valid.
  typedef struct packed {
    logic [KEY_WIDTH-1:0]   low;
    logic [KEY_WIDTH-1:0]   high;
    logic                   high_ok;
    logic [2:0][AW-1:0]     link;
  } node_t;

  tkte_pkg::state_t state, state_next;

  node_t            mem [NODE_COUNT];
  node_t            rd_q;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  node_t            mem_wdata;

  logic                        req_q;
  logic signed [KEY_WIDTH-1:0] key_q;
  logic [AW-1:0]               node, node_next;
  logic [CW-1:0]               nodes_used, nodes_used_next;
  logic                        root_valid, root_valid_next;
  logic                        le_lo, le_lo_next;
  logic                        res_found, res_found_next;
  logic                        res_status, res_status_next;

  // Shared comparator: the low key in S_CMP_LO, the high key otherwise.
  logic signed [KEY_WIDTH-1:0] cmp_operand;
  logic                        cmp_lt;
  logic                        cmp_eq;

  logic                        is_search;
  logic                        node_empty;
  logic                        pool_full;
  logic                        out_free;
  tkte_pkg::branch_t           branch;
  logic [AW-1:0]               child;
  logic                        child_none;

  assign cmp_operand = (state == tkte_pkg::S_CMP_LO) ? rd_q.low : rd_q.high;
  assign cmp_lt      = key_q < cmp_operand;
  assign cmp_eq      = key_q == cmp_operand;

  assign is_search  = (req_q == tkte_pkg::REQ_SEARCH);
  assign node_empty = (node == '0) && !root_valid;
  assign pool_full  = (nodes_used == CW'(NODE_COUNT));
  assign out_free   = !out_valid || out_ready;

  // Branch choice in S_CMP_HI: le_lo holds key <= low from the previous pass,
  // and the comparator now shows key against the high key.
  always_comb begin
    if (le_lo) begin
      branch = tkte_pkg::BR_LEFT;
    end else if (!cmp_lt && !cmp_eq) begin
      branch = tkte_pkg::BR_RIGHT;
    end else begin
      branch = tkte_pkg::BR_MID;
    end
  end

  assign child      = rd_q.link[branch];
  assign child_none = (child == '0);

  assign in_ready = (state == tkte_pkg::S_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      tkte_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = tkte_pkg::S_FETCH;
        end
      end
      tkte_pkg::S_FETCH: begin
        state_next = node_empty ? tkte_pkg::S_DONE : tkte_pkg::S_CMP_LO;
      end
      tkte_pkg::S_CMP_LO: begin
        if ((is_search && cmp_eq) || !rd_q.high_ok) begin
          state_next = tkte_pkg::S_DONE;
        end else begin
          state_next = tkte_pkg::S_CMP_HI;
        end
      end
      tkte_pkg::S_CMP_HI: begin
        if (is_search && cmp_eq) begin
          state_next = tkte_pkg::S_DONE;
        end else if (!child_none) begin
          state_next = tkte_pkg::S_FETCH;
        end else if (is_search || pool_full) begin
          state_next = tkte_pkg::S_DONE;
        end else begin
          state_next = tkte_pkg::S_ALLOC;
        end
      end
      tkte_pkg::S_ALLOC: begin
        state_next = tkte_pkg::S_DONE;
      end
      tkte_pkg::S_DONE: begin
        if (out_free) begin
          state_next = tkte_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tkte_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath controls: memory writes, walk position, pool count, result.
  always_comb begin
    mem_we          = 1'b0;
    mem_waddr       = node;
    mem_wdata       = rd_q;
    node_next       = node;
    nodes_used_next = nodes_used;
    root_valid_next = root_valid;
    le_lo_next      = le_lo;
    res_found_next  = res_found;
    res_status_next = res_status;
    unique case (state)
      tkte_pkg::S_IDLE: begin
        node_next       = '0;
        res_found_next  = 1'b0;
        res_status_next = tkte_pkg::STAT_DONE;
      end
      tkte_pkg::S_FETCH: begin
        // An empty tree: an insert fills the root's low key, a search misses.
        if (node_empty && !is_search) begin
          mem_we          = 1'b1;
          mem_wdata.low   = key_q;
          mem_wdata.high  = key_q;
          mem_wdata.high_ok = 1'b0;
          mem_wdata.link  = '0;
          root_valid_next = 1'b1;
        end
      end
      tkte_pkg::S_CMP_LO: begin
        le_lo_next = cmp_lt || cmp_eq;
        if (is_search) begin
          if (cmp_eq) begin
            res_found_next = 1'b1;
          end
        end else if (!rd_q.high_ok) begin
          // Second key of the node; keep the pair in order.
          mem_we            = 1'b1;
          mem_wdata.high_ok = 1'b1;
          if (cmp_lt) begin
            mem_wdata.low  = key_q;
            mem_wdata.high = rd_q.low;
          end else begin
            mem_wdata.high = key_q;
          end
        end
      end
      tkte_pkg::S_CMP_HI: begin
        if (is_search && cmp_eq) begin
          res_found_next = 1'b1;
        end else if (!child_none) begin
          node_next = child;
        end else if (!is_search) begin
          if (pool_full) begin
            res_status_next = tkte_pkg::STAT_FULL;
          end else begin
            // Hook the next free node under the parent.
            mem_we                 = 1'b1;
            mem_wdata.link[branch] = nodes_used[AW-1:0];
            node_next              = nodes_used[AW-1:0];
          end
        end
      end
      tkte_pkg::S_ALLOC: begin
        mem_we            = 1'b1;
        mem_wdata.low     = key_q;
        mem_wdata.high    = key_q;
        mem_wdata.high_ok = 1'b0;
        mem_wdata.link    = '0;
        nodes_used_next   = nodes_used + CW'(1);
      end
      tkte_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Node pool memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state == tkte_pkg::S_FETCH) begin
      rd_q <= mem[node];
    end
  end

  // Request capture and walk registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_q <= req_type;
      key_q <= key;
    end
    node       <= node_next;
    le_lo      <= le_lo_next;
    res_found  <= res_found_next;
    res_status <= res_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tkte_pkg::S_IDLE;
      nodes_used <= CW'(1);
      root_valid <= 1'b0;
    end else begin
      state      <= state_next;
      nodes_used <= nodes_used_next;
      root_valid <= root_valid_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == tkte_pkg::S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tkte_pkg::S_DONE && out_free) begin
      found  <= res_found;
      status <= res_status;
    end
  end

  `TTE_ASSERT_HOLDS(a_pool_count_range, clk, rst, 1'b1,
    (nodes_used != '0) && (nodes_used <= CW'(NODE_COUNT)))
  `TTE_ASSERT_HOLDS(a_write_inside_pool, clk, rst, mem_we, ({1'b0, mem_waddr} <= nodes_used))
  `TTE_ASSERT_HOLDS(a_search_no_write, clk, rst,
    (state != tkte_pkg::S_IDLE) && is_search, !mem_we)
  `TTE_ASSERT_NEXT(a_count_only_on_alloc, clk, rst, state != tkte_pkg::S_ALLOC,
    $stable(nodes_used))
  `TTE_ASSERT_HOLDS(a_result_from_done, clk, rst, $rose(out_valid),
    $past(state) == tkte_pkg::S_DONE)

endmodule

`default_nettype wire
